[rtl/core/vus_pkg.sv]
// vus_pkg: shared types and constants of the video unit splitter.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps
package vus_pkg;

  localparam int PACKET_LEN_BITS_DEF      = 24;
  localparam int SIZE_FIELD_MAX_BYTES_DEF = 8;

  // width of the saturated bytes_left value: holds 2^31 and the 25-bit field
  localparam int BL_W = 33;

  // result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // split_mode bits: OBU wins over length prefix
  localparam int MODE_LEN_BIT = 0;
  localparam int MODE_OBU_BIT = 1;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [24:0] bytes_left;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       first_of_unit;
    logic       last_of_unit;
    logic       last_of_step;
  } out_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

[rtl/core/vus_front.sv]
// vus_front: per-byte parser; turns one accepted byte into a job of results.
// Depends on vus_pkg.
`timescale 1ns / 1ps
module vus_front #(
  parameter int PACKET_LEN_BITS      = vus_pkg::PACKET_LEN_BITS_DEF,
  parameter int SIZE_FIELD_MAX_BYTES = vus_pkg::SIZE_FIELD_MAX_BYTES_DEF,
  parameter int MAX_RES              = SIZE_FIELD_MAX_BYTES + 2,
  parameter int CW                   = $clog2(MAX_RES + 1),
  parameter int JW                   = MAX_RES * $bits(vus_pkg::out_t) + CW
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       mode,
  input  logic             take,
  input  vus_pkg::in_t     item,
  output logic             job_push,
  output logic [JW-1:0]    job_data
);
  import vus_pkg::*;

  localparam int IW = $clog2(MAX_RES);
  localparam logic [BL_W-1:0] PKT_MAX = BL_W'(1) << PACKET_LEN_BITS;

  typedef enum logic [12:0] {
    PH_IDLE      = 13'b0000000000001,
    PH_SC0       = 13'b0000000000010,
    PH_SC1       = 13'b0000000000100,
    PH_SC2       = 13'b0000000001000,
    PH_SC3       = 13'b0000000010000,
    PH_BODY      = 13'b0000000100000,
    PH_LEN       = 13'b0000001000000,
    PH_LEN_BODY  = 13'b0000010000000,
    PH_OBU_HDR   = 13'b0000100000000,
    PH_OBU_EXT   = 13'b0001000000000,
    PH_OBU_LEB   = 13'b0010000000000,
    PH_OBU_SIZED = 13'b0100000000000,
    PH_OBU_REST  = 13'b1000000000000
  } phase_t;

  typedef logic [MAX_RES-1:0][7:0] hold_arr_t;

  typedef struct packed {
    out_t [MAX_RES-1:0] res;
    logic [CW-1:0]      n;
    logic               uo;
  } acc_t;

  function automatic acc_t put(acc_t a, logic [7:0] by, logic [1:0] k, logic f, logic l);
    if (a.n < CW'(MAX_RES)) begin
      a.res[a.n[IW-1:0]] = '{out_byte: by, kind: k, first_of_unit: f,
                             last_of_unit: l, last_of_step: 1'b0};
      a.n = a.n + CW'(1);
    end
    return a;
  endfunction

  function automatic acc_t put_data(acc_t a, logic [7:0] by, logic l);
    a = put(a, by, KIND_BYTE, !a.uo, l);
    a.uo = !l;
    return a;
  endfunction

  function automatic acc_t put_empty(acc_t a);
    a = put(a, 8'd0, KIND_EMPTY, 1'b0, 1'b0);
    a.uo = 1'b0;
    return a;
  endfunction

  function automatic acc_t emit_held(acc_t a, hold_arr_t h, logic [CW-1:0] n, logic lastf);
    for (int i = 0; i < MAX_RES; i++) begin
      if (CW'(i) < n) a = put_data(a, h[i], lastf && (CW'(i + 1) == n));
    end
    return a;
  endfunction

  phase_t        phase, phase_next, ph;
  hold_arr_t     held, held_next, wk2;
  logic [CW-1:0] held_count, hc_n, keep, ne, n_before;
  logic [1:0]    zero_run, zr_n;
  logic [31:0]   unit_bytes_left, ubl_n;
  logic [31:0]   size_accumulator, acc_n;
  logic [3:0]    size_bytes_seen, seen_n;
  logic          unit_open, dropping, drop_n, done;
  logic [BL_W-1:0] bl;
  logic [6:0]    lsh;
  logic [63:0]   v;
  logic [7:0]    b;
  logic          e;
  acc_t          a;

  assign b = item.data_byte;

  always_comb begin
    bl = BL_W'(item.bytes_left);
    if (bl > PKT_MAX) bl = PKT_MAX;
    if (bl == '0) bl = BL_W'(1);
  end
  assign e = (bl == BL_W'(1));

  always_comb begin
    a = '0;
    a.uo = unit_open;
    phase_next = phase;
    ph = phase;
    held_next = held;
    wk2 = held;
    hc_n = held_count;
    zr_n = zero_run;
    ubl_n = unit_bytes_left;
    acc_n = size_accumulator;
    seen_n = size_bytes_seen;
    drop_n = dropping;
    keep = '0;
    ne = '0;
    n_before = '0;
    lsh = '0;
    v = '0;
    done = 1'b0;
    if (!dropping) begin
      if (phase == PH_IDLE) begin
        hc_n = '0;
        acc_n = '0;
        seen_n = '0;
        ph = mode[MODE_OBU_BIT] ? PH_OBU_HDR : mode[MODE_LEN_BIT] ? PH_LEN : PH_SC0;
        phase_next = ph;
      end
      unique case (ph)
        PH_SC0, PH_SC1: begin
          if (b != 8'd0 || e) begin
            a = put(a, 8'd0, KIND_ERROR, 1'b0, 1'b0);
            drop_n = 1'b1; hc_n = '0; a.uo = 1'b0;
          end else begin
            phase_next = (ph == PH_SC0) ? PH_SC1 : PH_SC2;
          end
        end
        PH_SC2, PH_SC3: begin
          if (b == 8'd1) begin
            phase_next = PH_BODY;
            hc_n = '0; zr_n = '0; a.uo = 1'b0;
            if (e) a = put_empty(a);
          end else if (ph == PH_SC2 && b == 8'd0 && !e) begin
            phase_next = PH_SC3;
          end else begin
            a = put(a, 8'd0, KIND_ERROR, 1'b0, 1'b0);
            drop_n = 1'b1; hc_n = '0; a.uo = 1'b0;
          end
        end
        PH_BODY: begin
          if (b == 8'd1 && zr_n == 2'd2 && hc_n >= CW'(2)) begin
            n_before = hc_n - CW'(2);
            if (n_before != '0) a = emit_held(a, held_next, n_before, 1'b1);
            else if (!a.uo) a = put_empty(a);
            hc_n = '0; zr_n = '0; a.uo = 1'b0;
            if (e) a = put_empty(a);
          end else begin
            if (hc_n < CW'(MAX_RES)) begin
              held_next[hc_n[IW-1:0]] = b;
              hc_n = hc_n + CW'(1);
            end
            zr_n = (b == 8'd0) ? ((zr_n < 2'd2) ? zr_n + 2'd1 : 2'd2) : 2'd0;
            keep = CW'(zr_n) + CW'(1);
            ne = (hc_n > keep) ? hc_n - keep : '0;
            for (int i = 0; i < MAX_RES; i++) begin
              if (CW'(i) < ne) a = put_data(a, held_next[i], 1'b0);
            end
            wk2 = held_next;
            for (int i = 0; i < MAX_RES; i++) begin
              if (i + int'(ne) < MAX_RES) wk2[i] = held_next[IW'(i + int'(ne))];
            end
            held_next = wk2;
            hc_n = hc_n - ne;
            if (e) begin
              a = emit_held(a, held_next, hc_n, 1'b1);
              hc_n = '0;
            end
          end
        end
        PH_LEN: begin
          acc_n = {acc_n[23:0], b};
          seen_n = seen_n + 4'd1;
          if (seen_n < 4'd4) begin
            if (e) begin
              a = put(a, 8'd0, KIND_ERROR, 1'b0, 1'b0);
              drop_n = 1'b1; hc_n = '0; a.uo = 1'b0;
            end
          end else if (acc_n[31] || BL_W'(acc_n) > bl - BL_W'(1)) begin
            a = put(a, 8'd0, KIND_ERROR, 1'b0, 1'b0);
            drop_n = 1'b1; hc_n = '0; a.uo = 1'b0;
          end else if (acc_n == '0) begin
            a = put_empty(a);
            acc_n = '0; seen_n = '0; hc_n = '0;
          end else begin
            ubl_n = acc_n;
            a.uo = 1'b0;
            phase_next = PH_LEN_BODY;
          end
        end
        PH_LEN_BODY, PH_OBU_SIZED: begin
          a = put_data(a, b, (ubl_n <= 32'd1) || e);
          if (ubl_n != '0) ubl_n = ubl_n - 32'd1;
          if (ubl_n == '0) begin
            phase_next = (ph == PH_LEN_BODY) ? PH_LEN : PH_OBU_HDR;
            acc_n = '0; seen_n = '0; hc_n = '0;
          end
        end
        PH_OBU_HDR: begin
          acc_n = '0; seen_n = '0; hc_n = '0;
          a.uo = 1'b0;
          if (b[7] || b[0]) begin
            a = put(a, 8'd0, KIND_ERROR, 1'b0, 1'b0);
            drop_n = 1'b1; hc_n = '0; a.uo = 1'b0;
          end else begin
            held_next[0] = b;
            hc_n = CW'(1);
            if (b[2] || b[1]) begin
              if (e) begin
                a = put(a, 8'd0, KIND_ERROR, 1'b0, 1'b0);
                drop_n = 1'b1; hc_n = '0; a.uo = 1'b0;
              end else begin
                phase_next = b[2] ? PH_OBU_EXT : PH_OBU_LEB;
              end
            end else begin
              a = emit_held(a, held_next, hc_n, e);
              hc_n = '0;
              phase_next = PH_OBU_REST;
            end
          end
        end
        PH_OBU_EXT: begin
          if (b[2:0] != 3'd0) begin
            a = put(a, 8'd0, KIND_ERROR, 1'b0, 1'b0);
            drop_n = 1'b1; hc_n = '0; a.uo = 1'b0;
          end else begin
            if (hc_n < CW'(MAX_RES)) begin
              held_next[hc_n[IW-1:0]] = b;
              hc_n = hc_n + CW'(1);
            end
            if (held_next[0][1]) begin
              if (e) begin
                a = put(a, 8'd0, KIND_ERROR, 1'b0, 1'b0);
                drop_n = 1'b1; hc_n = '0; a.uo = 1'b0;
              end else begin
                phase_next = PH_OBU_LEB;
              end
            end else begin
              a = emit_held(a, held_next, hc_n, e);
              hc_n = '0;
              phase_next = PH_OBU_REST;
            end
          end
        end
        PH_OBU_LEB: begin
          if (hc_n < CW'(MAX_RES)) begin
            held_next[hc_n[IW-1:0]] = b;
            hc_n = hc_n + CW'(1);
          end
          lsh = 7'(seen_n) * 7'd7;
          v = 64'(b[6:0]) << lsh;
          if (v[63:32] != 32'd0) begin
            a = put(a, 8'd0, KIND_ERROR, 1'b0, 1'b0);
            drop_n = 1'b1; hc_n = '0; a.uo = 1'b0;
          end else begin
            acc_n = acc_n | v[31:0];
            seen_n = seen_n + 4'd1;
            done = !b[7] || (seen_n >= 4'(SIZE_FIELD_MAX_BYTES));
            if (!done) begin
              if (e) begin
                a = put(a, 8'd0, KIND_ERROR, 1'b0, 1'b0);
                drop_n = 1'b1; hc_n = '0; a.uo = 1'b0;
              end
            end else begin
              a = emit_held(a, held_next, hc_n, (acc_n == '0) || e);
              hc_n = '0;
              if (acc_n == '0) begin
                phase_next = PH_OBU_HDR;
              end else begin
                ubl_n = acc_n;
                phase_next = PH_OBU_SIZED;
              end
            end
          end
        end
        PH_OBU_REST: begin
          a = put_data(a, b, e);
        end
        default: begin
          a = put(a, 8'd0, KIND_ERROR, 1'b0, 1'b0);
          drop_n = 1'b1; hc_n = '0; a.uo = 1'b0;
        end
      endcase
    end
    if (e) begin
      phase_next = PH_IDLE;
      drop_n = 1'b0;
      hc_n = '0; zr_n = '0; ubl_n = '0; acc_n = '0; seen_n = '0;
      a.uo = 1'b0;
    end
  end

  assign job_push = take && (a.n != '0);
  assign job_data = {a.n, a.res};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      held_count       <= '0;
      zero_run         <= '0;
      unit_bytes_left  <= '0;
      size_accumulator <= '0;
      size_bytes_seen  <= '0;
      unit_open        <= 1'b0;
      dropping         <= 1'b0;
    end else if (take) begin
      phase            <= phase_next;
      held_count       <= hc_n;
      zero_run         <= zr_n;
      unit_bytes_left  <= ubl_n;
      size_accumulator <= acc_n;
      size_bytes_seen  <= seen_n;
      unit_open        <= a.uo;
      dropping         <= drop_n;
    end
  end

  always_ff @(posedge clk) begin
    if (take) held <= held_next;
  end

endmodule

[rtl/core/vus_queue.sv]
// vus_queue: two-entry job queue between front and back.
// Depends on vus_pkg for the status struct.
`timescale 1ns / 1ps
module vus_queue #(
  parameter int W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [W-1:0]     wdata,
  input  logic             rd,
  output logic [W-1:0]     rdata,
  output vus_pkg::q_stat_t stat
);
  import vus_pkg::*;

  logic [1:0][W-1:0] slot;
  logic              wptr, rptr;
  logic [1:0]        cnt;
  logic              do_wr, do_rd;

  assign stat.full  = (cnt == 2'd2);
  assign stat.empty = (cnt == 2'd0);
  assign do_wr = wr && !stat.full;
  assign do_rd = rd && !stat.empty;
  assign rdata = slot[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (do_wr) wptr <= !wptr;
      if (do_rd) rptr <= !rptr;
      cnt <= cnt + 2'(do_wr) - 2'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slot[wptr] <= wdata;
  end

endmodule

[rtl/core/vus_back.sv]
// vus_back: walks the head job one result per beat onto the result port.
// Depends on vus_pkg.
`timescale 1ns / 1ps
module vus_back #(
  parameter int MAX_RES = vus_pkg::SIZE_FIELD_MAX_BYTES_DEF + 2,
  parameter int CW      = $clog2(MAX_RES + 1),
  parameter int JW      = MAX_RES * $bits(vus_pkg::out_t) + CW
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [JW-1:0]    head,
  input  vus_pkg::q_stat_t stat,
  input  logic             pop,
  output logic             empty,
  output vus_pkg::out_t    result,
  output logic             q_pop
);
  import vus_pkg::*;

  localparam int IW = $clog2(MAX_RES);

  out_t [MAX_RES-1:0] res;
  logic [CW-1:0]      n;
  logic [IW-1:0]      idx;
  logic               last, beat;

  assign n    = head[JW-1 -: CW];
  assign res  = head[JW-CW-1:0];
  assign last = (CW'(idx) + CW'(1) == n);
  assign empty = stat.empty;
  assign beat  = pop && !stat.empty;
  assign q_pop = beat && last;

  always_comb begin
    result = res[idx];
    result.last_of_step = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (beat) begin
      idx <= last ? '0 : idx + IW'(1);
    end
  end

endmodule

[rtl/core/video_unit_splitter.sv]
// video_unit_splitter: top level; front parser, job queue and result walker.
// Depends on vus_pkg, vus_front, vus_queue, vus_back.
`timescale 1ns / 1ps
// Packet bytes go in on the item port, one per beat, with the count of bytes
// left in the packet; coded units come out on the result port, one result per
// beat, in order. split_mode picks start-code, 4-byte length or OBU splitting
// and is sampled on a packet's first byte. The front takes one byte per cycle
// while the queue is not full, and turns it into a job of zero to
// SIZE_FIELD_MAX_BYTES+2 results; a two-entry job queue sits between it and
// the back, which drives one result per cycle while pop is high. Bytes
// yielding one result stream at one per cycle while pop stays high, and
// full rises only when both queue slots hold jobs the back has not finished.
module video_unit_splitter #(
  parameter int PACKET_LEN_BITS      = vus_pkg::PACKET_LEN_BITS_DEF,
  parameter int SIZE_FIELD_MAX_BYTES = vus_pkg::SIZE_FIELD_MAX_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  vus_pkg::in_t  item,
  output logic          empty,
  input  logic          pop,
  output vus_pkg::out_t result,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_data
);
  import vus_pkg::*;

  localparam int MAX_RES = SIZE_FIELD_MAX_BYTES + 2;
  localparam int CW      = $clog2(MAX_RES + 1);
  localparam int JW      = MAX_RES * $bits(out_t) + CW;

  logic [1:0]    split_mode;
  logic          take, q_push, q_pop;
  logic [JW-1:0] job, head;
  q_stat_t       q_stat;

  // config register; always ready; to be written only while idle, which the block does not enforce
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      split_mode <= 2'd0;
    end else if (cfg_valid && cfg_ready) begin
      split_mode <= cfg_data;
    end
  end

  assign full = q_stat.full;
  assign take = push && !full;

  vus_front #(
    .PACKET_LEN_BITS(PACKET_LEN_BITS),
    .SIZE_FIELD_MAX_BYTES(SIZE_FIELD_MAX_BYTES),
    .MAX_RES(MAX_RES), .CW(CW), .JW(JW)
  ) u_front (
    .clk(clk), .rst(rst), .mode(split_mode), .take(take), .item(item),
    .job_push(q_push), .job_data(job)
  );

  vus_queue #(.W(JW)) u_queue (
    .clk(clk), .rst(rst), .wr(q_push), .wdata(job), .rd(q_pop),
    .rdata(head), .stat(q_stat)
  );

  vus_back #(.MAX_RES(MAX_RES), .CW(CW), .JW(JW)) u_back (
    .clk(clk), .rst(rst), .head(head), .stat(q_stat), .pop(pop),
    .empty(empty), .result(result), .q_pop(q_pop)
  );

  // front never hands a job to a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("job pushed into full queue");

  // queued jobs always carry at least one result
  a_job_nonempty: assert property (@(posedge clk) disable iff (rst)
    !q_stat.empty |-> (head[JW-1 -: CW] != '0))
    else $error("empty job in queue");

  // marker results carry no byte and no unit flags
  a_marker_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.kind != KIND_BYTE) |->
      (result.out_byte == 8'd0 && !result.first_of_unit && !result.last_of_unit))
    else $error("marker result with data");

endmodule

[tb/video_unit_splitter_tb.sv]
// video_unit_splitter_tb: self-checking bench for the video unit splitter.
// Depends on vus_pkg and video_unit_splitter; drives packets, checks results.
`timescale 1ns / 1ps
module video_unit_splitter_tb;
  import vus_pkg::*;

  localparam int PKT_BITS  = 24;
  localparam int LEB_MAX   = 8;
  localparam int HOLD_MAX  = 2 + LEB_MAX;

  // split modes
  localparam logic [1:0] MODE_SC  = 2'd0;
  localparam logic [1:0] MODE_LEN = 2'd1;
  localparam logic [1:0] MODE_OBU = 2'd2;
  localparam logic [1:0] MODE_OBU3 = 2'd3;

  // parser phases
  typedef enum int {
    PH_IDLE, PH_SC0, PH_SC1, PH_SC2, PH_SC3, PH_BODY, PH_LEN, PH_LEN_BODY,
    PH_OBU_HDR, PH_OBU_EXT, PH_OBU_LEB, PH_OBU_SIZED, PH_OBU_REST
  } phase_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  in_t item = '0;
  logic empty;
  logic pop = 1'b0;
  out_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_data = '0;

  video_unit_splitter u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------
  // Predictor state: mirror of the splitter's parse state.
  // ---------------------------------------------------------------
  logic [1:0]  m_mode;
  phase_e      m_phase;
  logic [7:0]  m_held[HOLD_MAX];
  int unsigned m_held_n;
  int unsigned m_zeros;
  logic [63:0] m_unit_left;
  logic [31:0] m_size;
  int unsigned m_size_n;
  bit          m_open;
  bit          m_drop;

  out_t expected_q[$];   // results still owed by the block
  out_t step_res[$];     // results of the byte being predicted
  int   n_err;
  int   n_beats_out;
  int   n_units;

  function automatic out_t mk(logic [7:0] b, logic [1:0] k, bit f, bit l);
    out_t r;
    r.out_byte = b; r.kind = k; r.first_of_unit = f; r.last_of_unit = l;
    r.last_of_step = 1'b0;
    return r;
  endfunction

  task automatic put(logic [7:0] b, logic [1:0] k, bit f, bit l);
    if (step_res.size() < 10) step_res.push_back(mk(b, k, f, l));
  endtask

  task automatic put_byte(logic [7:0] b, bit l);
    put(b, KIND_BYTE, !m_open, l);
    m_open = !l;
  endtask

  task automatic put_empty();
    put(8'h00, KIND_EMPTY, 0, 0);
    m_open = 0;
  endtask

  task automatic put_error();
    put(8'h00, KIND_ERROR, 0, 0);
    m_drop = 1; m_held_n = 0; m_open = 0;
  endtask

  task automatic flush_held(int unsigned n, bit l);
    for (int unsigned i = 0; i < n && i < HOLD_MAX; i++)
      put_byte(m_held[i], l && (i + 1 == n));
  endtask

  task automatic hold(logic [7:0] b);
    if (m_held_n < HOLD_MAX) begin
      m_held[m_held_n] = b;
      m_held_n++;
    end
  endtask

  task automatic clear_size();
    m_size = 0; m_size_n = 0; m_held_n = 0;
  endtask

  task automatic packet_done();
    m_phase = PH_IDLE; m_drop = 0; m_held_n = 0; m_zeros = 0;
    m_unit_left = 0; m_size = 0; m_size_n = 0; m_open = 0;
  endtask

  task automatic open_body(bit e);
    m_phase = PH_BODY; m_held_n = 0; m_zeros = 0; m_open = 0;
    if (e) put_empty();
  endtask

  // Start-code body: hold back zeros that may start a 00 00 01.
  task automatic sc_body(logic [7:0] b, bit e);
    int unsigned keep;
    if (b == 8'h01 && m_zeros == 2 && m_held_n >= 2) begin
      if (m_held_n > 2) flush_held(m_held_n - 2, 1);
      else if (!m_open) put_empty();
      m_held_n = 0; m_zeros = 0; m_open = 0;
      if (e) put_empty();
      return;
    end
    hold(b);
    m_zeros = (b == 0) ? ((m_zeros < 2) ? m_zeros + 1 : 2) : 0;
    keep = m_zeros + 1;
    while (m_held_n > keep) begin
      put_byte(m_held[0], 0);
      for (int unsigned i = 0; i + 1 < m_held_n; i++) m_held[i] = m_held[i + 1];
      m_held_n--;
    end
    if (e) begin
      flush_held(m_held_n, 1);
      m_held_n = 0;
    end
  endtask

  task automatic leb_step(logic [7:0] b, bit e);
    logic [63:0] v;
    bit done;
    hold(b);
    v = 64'(b[6:0]) << (7 * (m_size_n & 15));
    if (v[63:32] != 0) begin
      put_error();
      return;
    end
    m_size = m_size | v[31:0];
    m_size_n++;
    done = !b[7] || m_size_n >= LEB_MAX;
    if (!done) begin
      if (e) put_error();
      return;
    end
    flush_held(m_held_n, (m_size == 0) || e);
    m_held_n = 0;
    if (m_size == 0) m_phase = PH_OBU_HDR;
    else begin
      m_unit_left = 64'(m_size);
      m_phase = PH_OBU_SIZED;
    end
  endtask

  // Works out the results of one accepted byte and queues them.
  task automatic predict_split(in_t it);
    logic [7:0] b;
    logic [63:0] bl;
    bit e;
    b = it.data_byte;
    bl = 64'(it.bytes_left);
    if (bl > (64'd1 << PKT_BITS)) bl = 64'd1 << PKT_BITS;
    if (bl == 0) bl = 1;
    e = (bl == 1);
    step_res.delete();
    if (!m_drop) begin
      if (m_phase == PH_IDLE) begin
        clear_size();
        m_phase = m_mode[MODE_OBU_BIT] ? PH_OBU_HDR :
                  m_mode[MODE_LEN_BIT] ? PH_LEN : PH_SC0;
      end
      case (m_phase)
        PH_SC0, PH_SC1: begin
          if (b != 0 || e) put_error();
          else m_phase = phase_e'(m_phase + 1);
        end
        PH_SC2: begin
          if (b == 1) open_body(e);
          else if (b == 0 && !e) m_phase = PH_SC3;
          else put_error();
        end
        PH_SC3: begin
          if (b == 1) open_body(e);
          else put_error();
        end
        PH_BODY: sc_body(b, e);
        PH_LEN: begin
          m_size = {m_size[23:0], b};
          m_size_n++;
          if (m_size_n < 4) begin
            if (e) put_error();
          end else if (m_size[31] || 64'(m_size) > bl - 1) begin
            put_error();
          end else if (m_size == 0) begin
            put_empty();
            clear_size();
          end else begin
            m_unit_left = 64'(m_size);
            m_open = 0;
            m_phase = PH_LEN_BODY;
          end
        end
        PH_LEN_BODY, PH_OBU_SIZED: begin
          put_byte(b, m_unit_left <= 1 || e);
          if (m_unit_left > 0) m_unit_left--;
          if (m_unit_left == 0) begin
            m_phase = (m_phase == PH_LEN_BODY) ? PH_LEN : PH_OBU_HDR;
            clear_size();
          end
        end
        PH_OBU_HDR: begin
          clear_size();
          m_open = 0;
          if (b[7] || b[0]) put_error();
          else begin
            hold(b);
            if (b[2]) begin
              if (e) put_error(); else m_phase = PH_OBU_EXT;
            end else if (b[1]) begin
              if (e) put_error(); else m_phase = PH_OBU_LEB;
            end else begin
              flush_held(m_held_n, e);
              m_held_n = 0;
              m_phase = PH_OBU_REST;
            end
          end
        end
        PH_OBU_EXT: begin
          if (b[2:0] != 0) put_error();
          else begin
            hold(b);
            if (m_held[0][1]) begin
              if (e) put_error(); else m_phase = PH_OBU_LEB;
            end else begin
              flush_held(m_held_n, e);
              m_held_n = 0;
              m_phase = PH_OBU_REST;
            end
          end
        end
        PH_OBU_LEB: leb_step(b, e);
        PH_OBU_REST: put_byte(b, e);
        default: put_error();
      endcase
    end
    if (e) packet_done();
    if (step_res.size() > 0) step_res[step_res.size() - 1].last_of_step = 1'b1;
    foreach (step_res[i]) expected_q.push_back(step_res[i]);
  endtask

  // ---------------------------------------------------------------
  // Result checker: every popped beat against the oldest expectation.
  // ---------------------------------------------------------------
  int  rx_idle_pct = 0;
  int  tx_idle_pct = 0;
  bit  rx_hold = 0;     // long receiver hold-off, set by the pressure process

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %h", $time, result);
        n_err++;
      end else begin
        out_t exp_r;
        exp_r = expected_q.pop_front();
        if (result !== exp_r) begin
          $display("%0t: mismatch expected byte=%h kind=%0d f=%b l=%b s=%b",
                   $time, exp_r.out_byte, exp_r.kind, exp_r.first_of_unit,
                   exp_r.last_of_unit, exp_r.last_of_step);
          $display("%0t:          actual   byte=%h kind=%0d f=%b l=%b s=%b",
                   $time, result.out_byte, result.kind, result.first_of_unit,
                   result.last_of_unit, result.last_of_step);
          n_err++;
        end
        n_beats_out++;
        if (result.kind == KIND_BYTE && result.last_of_unit) n_units++;
      end
    end
  end

  // Receiver: random pops, off during the pressure hold.
  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  // ---------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------
  // Offers one byte; returns once the block accepts it. push stays high
  // so the next byte can follow in the next cycle.
  task automatic send_byte(logic [7:0] b, logic [24:0] bl);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= '{data_byte: b, bytes_left: bl};
    @(posedge clk);
    while (full) @(posedge clk);
    predict_split('{data_byte: b, bytes_left: bl});
  endtask

  // Sends a packet of n bytes; bytes_left counts down to 1.
  task automatic send_packet(logic [7:0] pkt[$]);
    for (int i = 0; i < pkt.size(); i++)
      send_byte(pkt[i], 25'(pkt.size() - i));
  endtask

  task automatic drain();
    push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);   // a byte may still be in flight with no result
  endtask

  task automatic set_mode(logic [1:0] m);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    m_mode = m;
  endtask

  // Random packet content shaped for the current mode.
  task automatic rand_packet(output logic [7:0] pkt[$]);
    int n;
    int len;
    pkt.delete();
    if ($urandom_range(9) == 0) begin   // noise
      n = $urandom_range(1, 8);
      repeat (n) pkt.push_back(8'($urandom));
      return;
    end
    if (!m_mode[MODE_OBU_BIT] && !m_mode[MODE_LEN_BIT]) begin
      if ($urandom_range(1)) pkt.push_back(8'h00);
      pkt.push_back(8'h00); pkt.push_back(8'h00); pkt.push_back(8'h01);
      n = $urandom_range(0, 10);
      repeat (n) begin
        case ($urandom_range(4))
          0: begin pkt.push_back(8'h00); pkt.push_back(8'h00); pkt.push_back(8'h01); end
          1, 2: pkt.push_back(8'h00);
          default: pkt.push_back(8'($urandom));
        endcase
      end
    end else if (!m_mode[MODE_OBU_BIT]) begin
      repeat ($urandom_range(1, 2)) begin
        len = $urandom_range(0, 5);
        if ($urandom_range(7) == 0) len = len + $urandom_range(1, 3); // overruns
        pkt.push_back(8'h00); pkt.push_back(8'h00); pkt.push_back(8'h00);
        pkt.push_back(8'(len));
        repeat ($urandom_range(len > 0 ? len - 1 : 0, len)) pkt.push_back(8'($urandom));
      end
    end else begin
      repeat ($urandom_range(1, 2)) begin
        logic [7:0] hdr;
        hdr = {1'b0, 4'($urandom), 1'($urandom_range(3) == 0), 1'($urandom), 1'b0};
        if ($urandom_range(11) == 0) hdr[7] = 1'b1;
        if ($urandom_range(11) == 0) hdr[0] = 1'b1;
        pkt.push_back(hdr);
        if (hdr[2]) pkt.push_back({5'($urandom), ($urandom_range(7) == 0) ? 3'd1 : 3'd0});
        if (hdr[1]) begin
          len = $urandom_range(0, 4);
          if ($urandom_range(5) == 0) pkt.push_back(8'h80 | 8'(len));
          pkt.push_back(8'(len));
          repeat (len) pkt.push_back(8'($urandom));
        end else begin
          repeat ($urandom_range(0, 4)) pkt.push_back(8'($urandom));
        end
      end
    end
  endtask

  typedef struct {
    logic [1:0]  mode;     // mode to set before the row, or keep
    bit          set;
    logic [7:0]  b;
    logic [24:0] bl;
    bit          chk;      // typed-in expectation present
    out_t        want;
  } row_t;

  row_t dir_rows[$];

  task automatic add_row(bit set, logic [1:0] m, logic [7:0] b, logic [24:0] bl,
                         bit chk, out_t want);
    row_t r;
    r.set = set; r.mode = m; r.b = b; r.bl = bl; r.chk = chk; r.want = want;
    dir_rows.push_back(r);
  endtask

  // ---------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------
  initial begin
    logic [7:0] pkt[$];
    int n_items;
    out_t w;
    n_err = 0; n_beats_out = 0; n_units = 0; n_items = 0;
    m_mode = MODE_SC;
    packet_done();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: error codes and simple single-result rows typed in.
    w = mk(0, KIND_ERROR, 0, 0); w.last_of_step = 1;
    add_row(0, MODE_SC, 8'hFF, 25'd1, 1, w);            // bad start code
    add_row(0, MODE_SC, 8'h00, 25'd2, 0, '0);
    add_row(0, MODE_SC, 8'h00, 25'd1, 1, w);            // packet ends in start code
    add_row(0, MODE_SC, 8'h00, 25'd0, 1, w);            // zero length counts as one
    add_row(0, MODE_SC, 8'h00, 25'h1FFFFFF, 0, '0);     // saturating length
    add_row(0, MODE_SC, 8'h00, 25'h1FFFFFE, 0, '0);
    add_row(0, MODE_SC, 8'h00, 25'h1FFFFFD, 0, '0);     // four-byte code
    w = mk(0, KIND_EMPTY, 0, 0); w.last_of_step = 1;
    add_row(0, MODE_SC, 8'h01, 25'd1, 1, w);            // start code ends packet
    w = mk(0, KIND_ERROR, 0, 0); w.last_of_step = 1;
    add_row(1, MODE_LEN, 8'h80, 25'd4, 0, '0);          // size of 2^31 and up
    add_row(0, MODE_LEN, 8'h00, 25'd3, 0, '0);
    add_row(0, MODE_LEN, 8'h00, 25'd2, 0, '0);
    add_row(0, MODE_LEN, 8'h00, 25'd1, 1, w);
    add_row(0, MODE_LEN, 8'h00, 25'd1, 1, w);           // ends inside length
    add_row(1, MODE_OBU, 8'h80, 25'd1, 1, w);           // forbidden bit
    add_row(0, MODE_OBU, 8'h01, 25'd1, 1, w);           // reserved bit
    w = mk(8'h10, KIND_BYTE, 1, 1); w.last_of_step = 1;
    add_row(0, MODE_OBU, 8'h10, 25'd1, 1, w);           // one-byte OBU, no size
    add_row(1, MODE_OBU3, 8'h06, 25'd5, 0, '0);         // mode three, ext + size
    add_row(0, MODE_OBU3, 8'h00, 25'd4, 0, '0);
    add_row(0, MODE_OBU3, 8'h02, 25'd3, 0, '0);
    add_row(0, MODE_OBU3, 8'hAB, 25'd2, 0, '0);
    add_row(0, MODE_OBU3, 8'hCD, 25'd1, 0, '0);
    add_row(0, MODE_OBU3, 8'h02, 25'd9, 0, '0);         // LEB128 overflow
    for (int i = 0; i < 4; i++) add_row(0, MODE_OBU3, 8'hFF, 25'(8 - i), 0, '0);
    add_row(0, MODE_OBU3, 8'h7F, 25'd4, 0, '0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set) set_mode(dir_rows[i].mode);
      if (dir_rows[i].chk) begin
        drain();
        send_byte(dir_rows[i].b, dir_rows[i].bl);
        if (expected_q.size() != 1 || expected_q[0] !== dir_rows[i].want) begin
          $display("%0t: table row %0d expected %h actual prediction differs",
                   $time, i, dir_rows[i].want);
          n_err++;
        end
      end else begin
        send_byte(dir_rows[i].b, dir_rows[i].bl);
      end
      n_items++;
    end
    // finish the dropped packet
    send_byte(8'h00, 25'd3); send_byte(8'h00, 25'd2); send_byte(8'h00, 25'd1);
    n_items += 3;

    // Random part: three idling phases, each cycling through the modes.
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 81 : 0;
      rx_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 7 : 0;
      for (int m = 0; m < 4; m++) begin
        set_mode(logic'(0) ? MODE_SC : 2'(m));
        for (int k = 0; k < 3; k++) begin
          rand_packet(pkt);
          if (ph == 2 && m == 0 && k == 0) begin
            // receiver holds off while sender keeps pushing
            fork
              begin
                rx_hold = 1;
                repeat (300) @(posedge clk);
                rx_hold = 0;
              end
              send_packet(pkt);
            join
          end else begin
            send_packet(pkt);
          end
          n_items += pkt.size();
        end
      end
    end
    // top up random items in start-code mode, no idling
    set_mode(MODE_SC);
    while (n_items < 220) begin
      rand_packet(pkt);
      send_packet(pkt);
      n_items += pkt.size();
    end

    drain();
    $display("tb: %0d bytes in, %0d beats out, %0d units, all four split modes",
             n_items, n_beats_out, n_units);
    if (n_err == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

endmodule

[video_unit_splitter.f]
rtl/core/vus_pkg.sv
rtl/core/vus_front.sv
rtl/core/vus_queue.sv
rtl/core/vus_back.sv
rtl/core/video_unit_splitter.sv
tb/video_unit_splitter_tb.sv
